// ----- hdl/csc_pkg.sv -----
package csc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LENGTH_BITS = 16;
  localparam int WIN         = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W  = $clog2(STACK_DEPTH);
  localparam int FILL_W  = $clog2(WIN + 1);
  localparam int WIDX_W  = $clog2(WIN);
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [2:0] CFG_SET0 = 3'd0;
  localparam logic [2:0] CFG_SET1 = 3'd1;
  localparam logic [2:0] CFG_SET2 = 3'd2;
  localparam logic [2:0] CFG_SET3 = 3'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_ESC_END   = 4'd1;
  localparam logic [3:0] ERR_OCTAL     = 4'd2;
  localparam logic [3:0] ERR_STR_END   = 4'd3;
  localparam logic [3:0] ERR_EXP_END   = 4'd4;
  localparam logic [3:0] ERR_BAD_EXP   = 4'd5;
  localparam logic [3:0] ERR_CLOSE     = 4'd6;
  localparam logic [3:0] ERR_EXP_LINE  = 4'd7;
  localparam logic [3:0] ERR_OP_LINE   = 4'd8;
  localparam logic [3:0] ERR_COND_END  = 4'd9;
  localparam logic [3:0] ERR_LEN_OVF   = 4'd10;
  localparam logic [3:0] ERR_STACK_OVF = 4'd11;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    CTX_PAREN = 3'd0,
    CTX_ROUND = 3'd1,
    CTX_CURLY = 3'd2,
    CTX_DQ    = 3'd3,
    CTX_SQ    = 3'd4,
    CTX_BQ    = 3'd5,
    CTX_RE    = 3'd6
  } ctx_t;

  typedef enum logic [1:0] {
    ST_FEED  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  typedef struct packed {
    logic [7:0] text;
    logic       eol;
    logic       term;
  } csc_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               drain;
    logic               done;
  } csc_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic ctx_t quote_ctx(input logic [7:0] c);
    return (c == CH_DQUOTE) ? CTX_DQ : ((c == CH_SQUOTE) ? CTX_SQ : CTX_BQ);
  endfunction

endpackage

// ----- hdl/csc_in_if.sv -----
interface csc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink (input valid, input text_byte, input end_of_line, output ready);
endinterface

// ----- hdl/csc_out_if.sv -----
interface csc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] span_length;
  logic        failed;
  logic [3:0]  error_code;
  logic        unclosed_paren;

  modport source (output valid, output span_length, output failed, output error_code,
                  output unclosed_paren, input ready);
  modport sink (input valid, input span_length, input failed, input error_code,
                input unclosed_paren, output ready);
endinterface

// ----- hdl/csc_front.sv -----
module csc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  csc_in_if.sink              text,
  input  logic                q_full,
  output logic                q_push,
  output csc_pkg::csc_word_t  q_word,
  output logic                term_zero
);
  import csc_pkg::*;

  logic [63:0]  term_set [4];
  logic [255:0] term_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) term_set[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET0: term_set[0] <= cfg_data;
        CFG_SET1: term_set[1] <= cfg_data;
        CFG_SET2: term_set[2] <= cfg_data;
        CFG_SET3: term_set[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign term_map = {term_set[3], term_set[2], term_set[1], term_set[0]};

  assign text.ready  = !q_full;
  assign q_push      = text.valid && !q_full;
  assign q_word.text = text.text_byte;
  assign q_word.eol  = text.end_of_line;
  // tag terminal bytes on the way in
  assign q_word.term = term_map[text.text_byte];
  // a byte past the line reads as code zero
  assign term_zero   = term_map[0];
endmodule

// ----- hdl/csc_queue.sv -----
module csc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csc_pkg::csc_word_t push_word,
  output logic               full,
  input  logic               pop,
  output csc_pkg::csc_word_t pop_word,
  output logic               nonempty
);
  import csc_pkg::*;

  csc_word_t          slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0]  wr_ptr;
  logic [QIDX_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign pop_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- hdl/csc_back.sv -----
module csc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  csc_pkg::csc_word_t   q_word,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic                 term_zero,
  csc_out_if.source            result,
  output csc_pkg::csc_status_t status
);
  import csc_pkg::*;

  logic [7:0]             win [WIN];
  logic                   wterm [WIN];
  logic [FILL_W-1:0]      fill;
  logic [LEVEL_W-1:0]     level;
  ctx_t                   stack [STACK_DEPTH];
  logic [LENGTH_BITS-1:0] pos;
  logic                   regex;
  logic                   done;
  state_t                 state;

  logic                   go, feeding, active, ovf, append, eol_now, do_step;
  logic [7:0]             sw [WIN];
  logic                   st [WIN];
  logic [7:0]             a [WIN];
  logic                   p [WIN];
  logic [FILL_W-1:0]      sf;
  logic [LENGTH_BITS-1:0] sp;
  logic [LENGTH_BITS-1:0] here;
  ctx_t                   top;
  logic [7:0]             c, b1, q, e;
  logic                   t0;

  logic                   fin, fopen, want_push, pop_en, rx_next, stack_full;
  logic [3:0]             code;
  logic [2:0]             cons;
  ctx_t                   pctx;
  logic                   fin_any, fin_ovf, done_after;
  logic [7:0]             nw [WIN];
  logic                   nt [WIN];
  logic [3:0]             src;

  assign go      = !result.valid || result.ready;
  assign feeding = state == ST_FEED;
  assign q_pop   = go && feeding && q_valid;
  assign active  = q_pop || (go && state == ST_DRAIN);
  assign ovf     = !done && (pos >= LEN_MAX);
  assign append  = q_pop && !done && !ovf;
  assign fin_ovf = q_pop && ovf;
  assign eol_now = feeding ? q_word.eol : 1'b1;
  assign sf      = append ? fill + 1'b1 : fill;
  assign sp      = append ? pos + 1'b1 : pos;
  assign do_step = feeding ? (append && (q_word.eol || sf == FILL_W'(WIN))) : active;
  assign here    = sp - LENGTH_BITS'(sf);
  assign stack_full = level == LEVEL_W'(STACK_DEPTH);
  assign top     = (level == '0) ? CTX_PAREN : stack[SIDX_W'(level - 1'b1)];

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      if (append && fill == FILL_W'(i)) begin
        sw[i] = q_word.text;
        st[i] = q_word.term;
      end else begin
        sw[i] = win[i];
        st[i] = wterm[i];
      end
      p[i] = FILL_W'(i) >= sf;
      a[i] = p[i] ? 8'h00 : sw[i];
    end
  end

  assign c  = a[0];
  assign b1 = a[1];
  assign t0 = p[0] ? term_zero : st[0];

  always_comb begin
    case (top)
      CTX_DQ:  q = CH_DQUOTE;
      CTX_SQ:  q = CH_SQUOTE;
      CTX_BQ:  q = CH_BQUOTE;
      default: q = CH_SLASH;
    endcase
    e = (top == CTX_CURLY) ? CH_RCURLY : CH_RPAREN;
  end

  // one scan step on the current window
  always_comb begin
    fin       = 1'b0;
    code      = ERR_NONE;
    fopen     = 1'b0;
    cons      = 3'd0;
    want_push = 1'b0;
    pctx      = CTX_PAREN;
    pop_en    = 1'b0;
    rx_next   = regex;
    case (top)
      CTX_PAREN: begin
        if (p[0]) begin
          fin = 1'b1; code = t0 ? ERR_NONE : ERR_COND_END; fopen = level != '0;
        end else if (is_space(c)) begin
          cons = 3'd1;
        end else if (level == '0 && t0) begin
          fin = 1'b1;
        end else if (c == CH_LPAREN) begin
          want_push = 1'b1; pctx = CTX_PAREN; cons = 3'd1; rx_next = 1'b0;
        end else if (c == CH_RPAREN) begin
          if (level == '0) begin
            fin = 1'b1; code = ERR_CLOSE;
          end else begin
            pop_en = 1'b1; cons = 3'd1; rx_next = 1'b0;
          end
        end else if (c == CH_DOLLAR || c == CH_PCT) begin
          if (p[2]) begin
            fin = 1'b1; code = ERR_EXP_LINE;
          end else if (b1 == CH_LCURLY || (c == CH_DOLLAR && b1 == CH_LPAREN)) begin
            if (p[3]) begin
              fin = 1'b1; code = ERR_BAD_EXP;
            end else begin
              want_push = 1'b1; cons = 3'd2;
              pctx = (b1 == CH_LCURLY) ? CTX_CURLY : CTX_ROUND;
            end
          end else begin
            cons = 3'd1; rx_next = 1'b0;
          end
        end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE
                     || (regex && c == CH_SLASH)) begin
          rx_next = 1'b0; want_push = 1'b1; cons = 3'd1;
          pctx = (c == CH_SLASH) ? CTX_RE : quote_ctx(c);
        end else if (c == CH_EQ || c == CH_BANG) begin
          if (p[2]) begin
            fin = 1'b1; code = ERR_OP_LINE;
          end else if (b1 == CH_TILDE) begin
            rx_next = 1'b1; cons = 3'd2;
          end else begin
            rx_next = 1'b0; cons = 3'd1;
          end
        end else if (c < 8'h20) begin
          fin = 1'b1; code = t0 ? ERR_NONE : ERR_COND_END; fopen = level != '0;
        end else begin
          rx_next = 1'b0;
          if (c != CH_BSLASH) begin
            cons = 3'd1;
          end else if (p[2] || b1 < 8'h20) begin
            fin = 1'b1; code = t0 ? ERR_NONE : ERR_COND_END; fopen = level != '0;
          end else begin
            cons = 3'd2;
          end
        end
      end
      CTX_ROUND, CTX_CURLY: begin
        if (p[0]) begin
          fin = 1'b1; code = ERR_EXP_END;
        end else if (c == e) begin
          pop_en = 1'b1; cons = 3'd1;
        end else if (c == CH_LPAREN) begin
          want_push = 1'b1; pctx = CTX_ROUND; cons = 3'd1;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE) begin
          want_push = 1'b1; pctx = quote_ctx(c); cons = 3'd1;
        end else if (c == CH_DOLLAR || c == CH_PCT) begin
          if (p[2]) begin
            fin = 1'b1; code = ERR_EXP_END;
          end else if (c == CH_PCT && b1 == CH_PCT) begin
            cons = 3'd2;
          end else if (b1 == CH_LCURLY || b1 == CH_LPAREN) begin
            if (p[3]) begin
              fin = 1'b1; code = ERR_BAD_EXP;
            end else begin
              want_push = 1'b1; cons = 3'd2;
              pctx = (b1 == CH_LCURLY) ? CTX_CURLY : CTX_ROUND;
            end
          end else begin
            cons = 3'd1;
          end
        end else if (c != CH_BSLASH) begin
          cons = 3'd1;
        end else if (p[2] || b1 < 8'h20) begin
          fin = 1'b1; code = ERR_EXP_END;
        end else begin
          cons = 3'd2;
        end
      end
      default: begin
        if (p[0]) begin
          fin = 1'b1; code = ERR_STR_END;
        end else if (c == q) begin
          pop_en = 1'b1; cons = 3'd1;
        end else if (c != CH_BSLASH) begin
          cons = 3'd1;
        end else if (p[2] || b1 < 8'h20) begin
          fin = 1'b1; code = ERR_ESC_END;
        end else if (!is_digit(b1)) begin
          cons = 3'd2;
        end else if (top == CTX_RE) begin
          cons = 3'd1;
        end else if (p[4]) begin
          fin = 1'b1; code = ERR_ESC_END;
        end else if (top == CTX_SQ && is_xdigit(a[2])) begin
          cons = 3'd3;
        end else if (!is_digit(a[2]) || !is_digit(a[3])) begin
          fin = 1'b1; code = ERR_OCTAL;
        end else begin
          cons = 3'd4;
        end
      end
    endcase
    if (want_push && stack_full) begin
      fin = 1'b1; code = ERR_STACK_OVF; fopen = 1'b0; cons = 3'd0; want_push = 1'b0;
    end
  end

  // shift out consumed bytes
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      src = 4'(i) + 4'(cons);
      if (src < 4'(WIN)) begin
        nw[i] = sw[WIDX_W'(src)];
        nt[i] = st[WIDX_W'(src)];
      end else begin
        nw[i] = 8'h00;
        nt[i] = 1'b0;
      end
    end
  end

  assign fin_any    = fin_ovf || (do_step && fin);
  assign done_after = done || fin_any;

  always_ff @(posedge clk) begin
    if (do_step) begin
      for (int i = 0; i < WIN; i++) begin
        win[i]   <= nw[i];
        wterm[i] <= nt[i];
      end
      if (want_push) stack[SIDX_W'(level)] <= pctx;
    end else if (append) begin
      for (int i = 0; i < WIN; i++) begin
        win[i]   <= sw[i];
        wterm[i] <= st[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_any) begin
      result.span_length    <= 16'(fin_ovf ? LEN_MAX : here);
      result.failed         <= fin_ovf || code != ERR_NONE;
      result.error_code     <= fin_ovf ? ERR_LEN_OVF : code;
      result.unclosed_paren <= fin_ovf ? 1'b0 : fopen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FEED;
      fill         <= '0;
      level        <= '0;
      pos          <= '0;
      regex        <= 1'b0;
      done         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (fin_any) result.valid <= 1'b1;
      if (do_step) begin
        fill  <= sf - FILL_W'(cons);
        pos   <= sp;
        regex <= rx_next;
        done  <= fin;
        if (want_push) level <= level + 1'b1;
        else if (pop_en) level <= level - 1'b1;
      end else if (append) begin
        fill <= sf;
        pos  <= sp;
      end
      if (fin_ovf) done <= 1'b1;
      if (active && eol_now) begin
        if (done_after) begin
          // line over: drop everything but the terminal set
          state <= ST_FEED;
          fill  <= '0;
          level <= '0;
          pos   <= '0;
          regex <= 1'b0;
          done  <= 1'b0;
        end else begin
          state <= ST_DRAIN;
        end
      end
    end
  end

  assign status.level = level;
  assign status.drain = state == ST_DRAIN;
  assign status.done  = done;
endmodule

// ----- hdl/condition_span_scanner.sv -----
// Condition span scanner.
// text: one byte of a condition line per word, end_of_line marks the last one.
// result: one word per line, the span length on success, or the failing offset
//   with failed set and an error code; both carry the unclosed-paren flag.
// cfg_we/cfg_index/cfg_data write the four 64-bit terminal-set bitmaps; write
//   them only while no line is in flight.
// Throughput: one text word per cycle within a line while the queue is not
//   full. Each byte is taken into a four-deep queue; the back end appends it
//   to a five-byte window and, when the window fills or the line ends, runs
//   one scan step in the same cycle. After the last byte of an undecided line
//   the back end drains the window one step per cycle while the result is
//   not stalled, and pops nothing meanwhile; the queue keeps taking bytes
//   of the next line until it is full.
// The result word is registered at the end of the cycle whose scan step
//   decides it.
// Reset clears the terminal sets, the queue, the scan state and result.valid.
// When the receiver stalls the result holds; the back end waits, the queue
//   fills and text.ready drops once it is full.
module condition_span_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  csc_in_if.sink      text,
  csc_out_if.source   result
);
  import csc_pkg::*;

  csc_word_t   push_word;
  csc_word_t   pop_word;
  logic        q_push, q_full, q_pop, q_nonempty, term_zero;
  csc_status_t status;

  csc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (push_word),
    .term_zero (term_zero)
  );

  csc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .nonempty  (q_nonempty)
  );

  csc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_word    (pop_word),
    .q_valid   (q_nonempty),
    .q_pop     (q_pop),
    .term_zero (term_zero),
    .result    (result),
    .status    (status)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    status.level <= LEVEL_W'(STACK_DEPTH))
    else $error("context stack level beyond depth");

  a_drain_open: assert property (@(posedge clk) disable iff (rst)
    status.drain |-> !status.done)
    else $error("draining a line that is already decided");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
endmodule

// ----- tb/condition_span_scanner_test.sv -----
`timescale 1ns / 100ps

module condition_span_scanner_test;
  import csc_pkg::*;

  typedef struct packed {
    logic [15:0] span;
    logic        failed;
    logic [3:0]  code;
    logic        open;
  } span_res_t;

  typedef struct {
    logic [7:0] fill_byte;
    int         fill_cnt;
    string      txt;
    bit         typed;
    span_res_t  want;
  } line_row_t;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  csc_in_if  text_if ();
  csc_out_if res_if ();

  condition_span_scanner i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .text(text_if), .result(res_if)
  );

  always #5 clk = ~clk;

  // scanner shadow state
  logic [63:0] term_map [4];
  ctx_t        nest [STACK_DEPTH];
  int unsigned depth, offset, fill;
  logic [7:0]  win [WIN];
  bit          re_ok, decided, have;
  span_res_t   verdict;

  span_res_t   pending_spans [$];
  int          errs = 0;
  bit          hold_req = 0;
  int          burst_left = 0;
  logic [7:0]  phase_terms [$];

  function automatic logic [7:0] peek(int unsigned k);
    return k < fill ? win[k] : 8'h00;
  endfunction

  function automatic bit gone(int unsigned k);
    return k >= fill;
  endfunction

  function automatic int unsigned here_pos();
    return offset - fill;
  endfunction

  function automatic bit terminal(logic [7:0] c);
    return term_map[c[7:6]][c[5:0]];
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit hexdig(logic [7:0] c);
    return digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic bit quote(logic [7:0] c);
    return c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BQUOTE;
  endfunction

  function automatic ctx_t quote_kind(logic [7:0] c);
    if (c == CH_DQUOTE) return CTX_DQ;
    if (c == CH_SQUOTE) return CTX_SQ;
    return CTX_BQ;
  endfunction

  function automatic void eat(int unsigned n);
    if (n > fill) n = fill;
    for (int i = 0; i + n < WIN; i++) win[i] = win[i + n];
    fill -= n;
  endfunction

  function automatic void decide(int unsigned len, logic [3:0] code, bit open);
    have = 1;
    decided = 1;
    verdict.span = len[15:0];
    verdict.failed = code != ERR_NONE;
    verdict.code = code;
    verdict.open = open;
  endfunction

  function automatic bit nest_push(ctx_t t);
    if (depth >= STACK_DEPTH) begin
      decide(here_pos(), ERR_STACK_OVF, 0);
      return 0;
    end
    nest[depth] = t;
    depth++;
    return 1;
  endfunction

  function automatic void leave_cond(logic [7:0] c);
    decide(here_pos(), terminal(c) ? ERR_NONE : ERR_COND_END, depth > 0);
  endfunction

  function automatic void scan_cond();
    logic [7:0] c, b1;
    c = peek(0);
    b1 = peek(1);
    if (gone(0)) begin
      leave_cond(8'h00);
    end else if (blank(c)) begin
      eat(1);
    end else if (depth == 0 && terminal(c)) begin
      decide(here_pos(), ERR_NONE, 0);
    end else if (c == CH_LPAREN) begin
      if (nest_push(CTX_PAREN)) begin
        eat(1);
        re_ok = 0;
      end
    end else if (c == CH_RPAREN) begin
      if (depth == 0) begin
        decide(here_pos(), ERR_CLOSE, 0);
      end else begin
        depth--;
        eat(1);
        re_ok = 0;
      end
    end else if (c == CH_DOLLAR || c == CH_PCT) begin
      if (gone(2)) begin
        decide(here_pos(), ERR_EXP_LINE, 0);
      end else if (b1 == CH_LCURLY || (c == CH_DOLLAR && b1 == CH_LPAREN)) begin
        if (gone(3)) decide(here_pos(), ERR_BAD_EXP, 0);
        else if (nest_push(b1 == CH_LCURLY ? CTX_CURLY : CTX_ROUND)) eat(2);
      end else begin
        eat(1);
        re_ok = 0;
      end
    end else if (quote(c) || (re_ok && c == CH_SLASH)) begin
      re_ok = 0;
      if (nest_push(c == CH_SLASH ? CTX_RE : quote_kind(c))) eat(1);
    end else if (c == CH_EQ || c == CH_BANG) begin
      if (gone(2)) begin
        decide(here_pos(), ERR_OP_LINE, 0);
      end else if (b1 == CH_TILDE) begin
        re_ok = 1;
        eat(2);
      end else begin
        eat(1);
        re_ok = 0;
      end
    end else if (c < 8'h20) begin
      leave_cond(c);
    end else begin
      re_ok = 0;
      if (c != CH_BSLASH) eat(1);
      else if (gone(2) || b1 < 8'h20) leave_cond(c);
      else eat(2);
    end
  endfunction

  function automatic void scan_string(ctx_t t);
    logic [7:0] q, c, b1;
    q = t == CTX_DQ ? CH_DQUOTE : (t == CTX_SQ ? CH_SQUOTE : (t == CTX_BQ ? CH_BQUOTE : CH_SLASH));
    c = peek(0);
    b1 = peek(1);
    if (gone(0)) decide(here_pos(), ERR_STR_END, 0);
    else if (c == q) begin
      depth--;
      eat(1);
    end else if (c != CH_BSLASH) eat(1);
    else if (gone(2) || b1 < 8'h20) decide(here_pos(), ERR_ESC_END, 0);
    else if (!digit(b1)) eat(2);
    else if (t == CTX_RE) eat(1);
    else if (gone(4)) decide(here_pos(), ERR_ESC_END, 0);
    else if (t == CTX_SQ && hexdig(peek(2))) eat(3);
    else if (!digit(peek(2)) || !digit(peek(3))) decide(here_pos(), ERR_OCTAL, 0);
    else eat(4);
  endfunction

  function automatic void scan_bracket(ctx_t t);
    logic [7:0] close_ch, c, b1;
    close_ch = t == CTX_CURLY ? CH_RCURLY : CH_RPAREN;
    c = peek(0);
    b1 = peek(1);
    if (gone(0)) decide(here_pos(), ERR_EXP_END, 0);
    else if (c == close_ch) begin
      depth--;
      eat(1);
    end else if (c == CH_LPAREN) begin
      if (nest_push(CTX_ROUND)) eat(1);
    end else if (quote(c)) begin
      if (nest_push(quote_kind(c))) eat(1);
    end else if (c == CH_DOLLAR || c == CH_PCT) begin
      if (gone(2)) decide(here_pos(), ERR_EXP_END, 0);
      else if (c == CH_PCT && b1 == CH_PCT) eat(2);
      else if (b1 == CH_LCURLY || b1 == CH_LPAREN) begin
        if (gone(3)) decide(here_pos(), ERR_BAD_EXP, 0);
        else if (nest_push(b1 == CH_LCURLY ? CTX_CURLY : CTX_ROUND)) eat(2);
      end else eat(1);
    end else if (c != CH_BSLASH) eat(1);
    else if (gone(2) || b1 < 8'h20) decide(here_pos(), ERR_EXP_END, 0);
    else eat(2);
  endfunction

  function automatic void clear_line();
    depth = 0;
    offset = 0;
    fill = 0;
    re_ok = 0;
    decided = 0;
  endfunction

  // advance the scan by one byte; have tells whether a span was decided
  function automatic void scan_byte(logic [7:0] b, bit eol);
    ctx_t top;
    have = 0;
    if (!decided) begin
      if (offset >= LEN_MAX) begin
        decide(LEN_MAX, ERR_LEN_OVF, 0);
      end else begin
        if (fill < WIN) begin
          win[fill] = b;
          fill++;
        end
        offset++;
        while (!decided && (eol || fill == WIN)) begin
          top = depth > 0 ? nest[depth - 1] : CTX_PAREN;
          if (top == CTX_PAREN) scan_cond();
          else if (top == CTX_ROUND || top == CTX_CURLY) scan_bracket(top);
          else scan_string(top);
        end
      end
    end
    if (eol) clear_line();
  endfunction

  task automatic send_word(logic [7:0] b, bit eol);
    if (burst_left == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    text_if.end_of_line <= eol;
    do @(posedge clk); while (!text_if.ready);
  endtask

  task automatic send_line(logic [7:0] bytes [$], bit typed, span_res_t want);
    foreach (bytes[i]) begin
      send_word(bytes[i], i == bytes.size() - 1);
      scan_byte(bytes[i], i == bytes.size() - 1);
      if (have) pending_spans.push_back(typed ? want : verdict);
    end
  endtask

  task automatic drain_spans();
    text_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_terms(logic [63:0] s0, logic [63:0] s1, logic [63:0] s2, logic [63:0] s3);
    logic [63:0] vals [4];
    vals = '{s0, s1, s2, s3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      term_map[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void put_str(ref logic [7:0] q [$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return $urandom_range(0, 3) == 0 ? 8'(8'h30 + $urandom_range(0, 9))
                                     : 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic void put_body(ref logic [7:0] q [$], input logic [7:0] close_ch);
    logic [7:0] c;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: begin
          q.push_back(CH_BSLASH);
          repeat ($urandom_range(1, 3)) q.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end
        1: begin
          q.push_back(CH_BSLASH);
          q.push_back(letter());
        end
        2: begin
          q.push_back(CH_BSLASH);
          q.push_back(8'(8'h30 + $urandom_range(0, 7)));
          q.push_back(8'(8'h41 + $urandom_range(0, 5)));
        end
        default: begin
          c = 8'($urandom_range(8'h20, 8'hFF));
          q.push_back(c == close_ch || c == CH_BSLASH ? letter() : c);
        end
      endcase
    end
  endfunction

  function automatic void put_expansion(ref logic [7:0] q [$], input int lvl);
    logic [7:0] close_ch;
    logic [7:0] qc;
    case ($urandom_range(0, 2))
      0: put_str(q, "%{");
      1: put_str(q, "${");
      default: put_str(q, "$(");
    endcase
    close_ch = q[q.size() - 1] == CH_LCURLY ? CH_RCURLY : CH_RPAREN;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0: if (lvl < 3) put_expansion(q, lvl + 1);
        1: if (lvl < 3) begin
          put_str(q, "%(");
          q.push_back(letter());
          q.push_back(CH_RPAREN);
        end
        2: begin
          qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          q.push_back(qc);
          put_body(q, qc);
          q.push_back(qc);
        end
        3: put_str(q, "%%");
        4: begin
          q.push_back(CH_BSLASH);
          q.push_back(letter());
        end
        default: q.push_back(letter());
      endcase
    end
    q.push_back(close_ch);
  endfunction

  function automatic void make_line(ref logic [7:0] q [$]);
    logic [7:0] qc;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 11))
        0, 1: repeat ($urandom_range(1, 5)) q.push_back(letter());
        2: q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'h09);
        3: q.push_back(CH_LPAREN);
        4: q.push_back(CH_RPAREN);
        5: begin
          put_str(q, $urandom_range(0, 1) ? " =~ /" : " !~ /");
          put_body(q, CH_SLASH);
          q.push_back(CH_SLASH);
        end
        6: put_str(q, $urandom_range(0, 1) ? " == " : " != ");
        7: begin
          case ($urandom_range(0, 2))
            0: qc = CH_DQUOTE;
            1: qc = CH_SQUOTE;
            default: qc = CH_BQUOTE;
          endcase
          q.push_back(qc);
          put_body(q, qc);
          q.push_back(qc);
        end
        8: put_expansion(q, 0);
        9: q.push_back(phase_terms[$urandom_range(0, phase_terms.size() - 1)]);
        10: q.push_back(8'($urandom_range(0, 255)));
        default: q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      endcase
    end
    // cut some lines short to hit the unfinished cases
    if (mode == 1 && q.size() > 1) q = q[0 : $urandom_range(0, q.size() - 2)];
  endfunction

  function automatic span_res_t mk(int unsigned len, logic [3:0] code, bit open);
    span_res_t r;
    r.span = len[15:0];
    r.failed = code != ERR_NONE;
    r.code = code;
    r.open = open;
    return r;
  endfunction

  // sender
  initial begin
    line_row_t rows [$];
    logic [7:0] bytes [$];
    logic [63:0] s0, s1, s2, s3;
    int sent;
    int lines;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SET0;
    cfg_data <= '0;
    text_if.valid <= 1'b0;
    text_if.text_byte <= '0;
    text_if.end_of_line <= 1'b0;
    for (int i = 0; i < 4; i++) term_map[i] = '0;
    clear_line();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{8'h00, 0, "a)", 1, mk(1, ERR_CLOSE, 0)},
      '{8'h00, 0, "a", 1, mk(1, ERR_COND_END, 0)},
      '{CH_LPAREN, 17, " a", 1, mk(16, ERR_STACK_OVF, 0)},
      '{8'h00, 0, "\"abc\\101\" == 'x\\41q'", 0, '0},
      '{8'h00, 0, "a =~ /b\\1c/ && d", 0, '0},
      '{8'h00, 0, "%{Foo:bar} $(x %(y) %{z})", 0, '0},
      '{8'h00, 0, "${a(b)\"c\\n\"} %{x%%y}", 0, '0},
      '{8'h00, 0, "\"abc", 0, '0},
      '{8'h00, 0, "\"ab\\9z\" x", 0, '0},
      '{8'h00, 0, "%{ab", 0, '0},
      '{8'h00, 0, "%{", 0, '0},
      '{8'h00, 0, "x $", 0, '0},
      '{8'h00, 0, "x =", 0, '0},
      '{8'h00, 0, "(a", 0, '0},
      '{8'h00, 0, "a \\", 0, '0},
      '{8'h00, 0, "\"\\", 0, '0},
      '{8'h00, 0, "\377\200 abc", 0, '0},
      '{8'h00, 0, "a\001b", 0, '0},
      '{8'h00, 0, "!~ `x` ${\"q", 0, '0}
    };
    foreach (rows[r]) begin
      bytes = {};
      repeat (rows[r].fill_cnt) bytes.push_back(rows[r].fill_byte);
      put_str(bytes, rows[r].txt);
      send_line(bytes, rows[r].typed, rows[r].want);
    end
    drain_spans();

    // every byte ends the condition
    write_terms('1, '1, '1, '1);
    rows = '{
      '{8'h00, 0, "abc", 1, mk(0, ERR_NONE, 0)},
      '{8'h00, 0, "(a)", 0, '0},
      '{8'h00, 0, "\tq", 0, '0},
      '{8'h00, 0, "\"x\" \001", 0, '0}
    };
    foreach (rows[r]) begin
      bytes = {};
      put_str(bytes, rows[r].txt);
      send_line(bytes, rows[r].typed, rows[r].want);
    end
    drain_spans();

    sent = 0;
    lines = 0;
    for (int ph = 0; ph < 4; ph++) begin
      phase_terms = {8'h00, 8'h26, 8'h7C, 8'h3B, CH_RPAREN, 8'h2C, CH_RCURLY, 8'h23, 8'h0A};
      phase_terms.shuffle();
      phase_terms = phase_terms[0 : $urandom_range(1, 4)];
      s0 = '0;
      s1 = '0;
      s2 = $urandom_range(0, 1) ? {$urandom, $urandom} & {$urandom, $urandom} : '0;
      s3 = ph == 3 ? '1 : '0;
      foreach (phase_terms[i]) begin
        if (phase_terms[i] < 8'h40) s0[phase_terms[i][5:0]] = 1'b1;
        else s1[phase_terms[i][5:0]] = 1'b1;
      end
      write_terms(s0, s1, s2, s3);
      if (ph == 1) hold_req = 1;
      while (sent < 115 * (ph + 1) || lines < 8 * (ph + 1)) begin
        bytes = {};
        make_line(bytes);
        send_line(bytes, 0, '0);
        sent += bytes.size();
        lines++;
      end
      drain_spans();
    end

    if (errs == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver: checks each word and stalls on its own pattern
  initial begin
    int hold_cnt;
    int mode_left;
    int mode;
    span_res_t got, want;
    hold_cnt = 0;
    mode_left = 0;
    mode = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got = '{res_if.span_length, res_if.failed, res_if.error_code, res_if.unclosed_paren};
        if (pending_spans.size() == 0) begin
          $error("unexpected span word %p", got);
          errs++;
        end else begin
          want = pending_spans.pop_front();
          if (got.span !== want.span) begin
            $error("span_length: expected %0d, got %0d", want.span, got.span);
            errs++;
          end
          if (got.failed !== want.failed) begin
            $error("failed: expected %0d, got %0d", want.failed, got.failed);
            errs++;
          end
          if (got.code !== want.code) begin
            $error("error_code: expected %0d, got %0d", want.code, got.code);
            errs++;
          end
          if (got.open !== want.open) begin
            $error("unclosed_paren: expected %0d, got %0d", want.open, got.open);
            errs++;
          end
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        // hold off long enough for the input side to back up
        hold_req = 0;
        hold_cnt = 300;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
